/* design/kdne_pkg.sv */
package kdne_pkg;

	// Field widths of the scan and event beats.
	localparam int KEY_W     = 13;
	localparam int TIME_W    = 32;
	localparam int DEB_W     = 16;
	localparam int OCT_W     = 4;
	localparam int NOTE_W    = 7;
	localparam int KIND_W    = 2;
	localparam int KIDX_W    = 4;
	localparam int NOTE_CALC_W = 9;

	// Configuration port.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE   = 1'd1;

	localparam logic [DEB_W-1:0] DEB_RESET = 16'd120;
	localparam logic [OCT_W-1:0] OCT_RESET = 4'd2;

	// Note numbering.
	localparam logic [NOTE_CALC_W-1:0] NOTES_PER_OCT = 9'd12;
	localparam logic [NOTE_CALC_W-1:0] NOTE_MAX      = 9'd127;

	localparam int NUM_KEYS_DEF = 13;

	typedef enum logic [KIND_W-1:0] {
		EV_NOTE_ON  = 2'd0,
		EV_NOTE_OFF = 2'd1,
		EV_HOLD_ON  = 2'd2,
		EV_HOLD_OFF = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_time;
		logic [OCT_W-1:0] octave;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [NOTE_W-1:0] note;
		logic [KIDX_W-1:0] key_index;
		logic              hold_active;
	} event_t;

endpackage

/* design/key_debounce_note_events.sv */
// Debounces a row of note keys plus a hold key and turns accepted changes
// into note events.
// Input channel (in_valid / in_stall): one beat per scan with a millisecond
// timestamp, the note key levels and the hold key level.
// Output channel (out_valid / out_stall): zero to NUM_KEYS+1 event beats per
// scan, in key order with the hold event at the end; the final beat of a scan
// carries last. A scan with no accepted change produces no beat.
// Configuration (cfg_we / cfg_idx / cfg_data) sets the debounce time and the
// octave; write it only while the block is idle.
// A scan is taken on the accept, then its key entries are evaluated in order
// with the hold entry last, since the per-key state sits in a RAM with one
// read per cycle, and the scan ends with the final flush. The first event of
// a scan waits in the pending slot and moves to the output register when the
// second change is found, or in the flush.
// While the receiver stalls, the output beat holds and evaluation pauses once
// a second event is waiting; in_stall stays high until the scan is finished.
// Reset clears the configuration to its defaults, releases all keys, sets
// all change times to zero and turns hold off, with no clearing pass.
module key_debounce_note_events #(
	parameter int NUM_KEYS = kdne_pkg::NUM_KEYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kdne_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [kdne_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [kdne_pkg::TIME_W-1:0]     time_ms,
	input  logic [kdne_pkg::KEY_W-1:0]      key_levels,
	input  logic                            hold_level,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kdne_pkg::KIND_W-1:0]     event_kind,
	output logic [kdne_pkg::NOTE_W-1:0]     note,
	output logic [kdne_pkg::KIDX_W-1:0]     key_index,
	output logic                            hold_active,
	output logic                            last
);

	import kdne_pkg::*;

	localparam int NE    = NUM_KEYS + 1;
	localparam int IDX_W = $clog2(NE);
	localparam int ENT_W = TIME_W + 1;

	cfg_t             cfg_q;
	event_t           ev;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENT_W-1:0] ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENT_W-1:0] ram_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DEB_RESET;
			cfg_q.octave        <= OCT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEBOUNCE: cfg_q.debounce_time <= cfg_data[DEB_W-1:0];
				REG_OCTAVE:   cfg_q.octave        <= cfg_data[OCT_W-1:0];
				default:      ;
			endcase
		end
	end

	// Per-key stable level and change time, hold key in the last entry.
	kdne_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NE)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	kdne_ctrl #(
		.NUM_KEYS(NUM_KEYS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.time_ms   (time_ms),
		.key_levels(key_levels),
		.hold_level(hold_level),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_event (ev),
		.out_last  (last)
	);

	assign event_kind  = ev.kind;
	assign note        = ev.note;
	assign key_index   = ev.key_index;
	assign hold_active = ev.hold_active;

endmodule

/* design/kdne_ram.sv */
module kdne_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds without a read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/kdne_ctrl.sv */
module kdne_ctrl #(
	parameter int NUM_KEYS = kdne_pkg::NUM_KEYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kdne_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kdne_pkg::TIME_W-1:0]   time_ms,
	input  logic [kdne_pkg::KEY_W-1:0]    key_levels,
	input  logic                          hold_level,
	output logic                          ram_we,
	output logic [$clog2(NUM_KEYS+1)-1:0] ram_waddr,
	output logic [kdne_pkg::TIME_W:0]     ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(NUM_KEYS+1)-1:0] ram_raddr,
	input  logic [kdne_pkg::TIME_W:0]     ram_rdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kdne_pkg::event_t              out_event,
	output logic                          out_last
);

	import kdne_pkg::*;

	localparam int NE    = NUM_KEYS + 1;
	localparam int IDX_W = $clog2(NE);
	localparam int LVL_W = (NUM_KEYS > KEY_W) ? NUM_KEYS : KEY_W;
	localparam logic [IDX_W-1:0] HOLD_IDX = IDX_W'(NUM_KEYS);

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q;
	logic [TIME_W-1:0]  now_q;
	logic [NE-1:0]      lvl_q;
	logic [NE-1:0]      entry_valid_q;
	logic               hold_on_q;
	logic               pend_valid_q;
	event_t             pend_q;
	logic               out_valid_q;
	event_t             out_q;
	logic               out_last_q;

	logic [LVL_W-1:0]       lvl_ext;
	logic [NE-1:0]          lvl_next;
	logic                   accept;
	logic                   stable;
	logic [TIME_W-1:0]      chg_time;
	logic [TIME_W-1:0]      elapsed;
	logic                   level;
	logic                   is_hold;
	logic                   change_ok;
	logic                   emits;
	logic                   hold_next;
	logic [NOTE_CALC_W-1:0] note_sum;
	event_t                 new_ev;
	logic                   out_free;
	logic                   advance;
	logic                   load_out;
	event_t                 load_ev;
	logic                   load_last;

	// Levels of one scan, hold key in the top position.
	assign lvl_ext  = LVL_W'(key_levels);
	assign lvl_next = {hold_level, lvl_ext[NUM_KEYS-1:0]};

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// An entry never written reads as released with change time zero.
	assign stable   = entry_valid_q[idx_q] ? ram_rdata[TIME_W] : 1'b0;
	assign chg_time = entry_valid_q[idx_q] ? ram_rdata[TIME_W-1:0] : '0;
	assign elapsed  = now_q - chg_time;
	assign level    = lvl_q[idx_q];
	assign is_hold  = (idx_q == HOLD_IDX);

	assign change_ok = (level != stable) &&
		(elapsed > TIME_W'(cfg.debounce_time));
	assign emits     = change_ok && (!is_hold || level);
	assign hold_next = !hold_on_q;

	// Note number of the current key; saturated when the event is built.
	assign note_sum = (NOTE_CALC_W'(cfg.octave) + NOTE_CALC_W'(1)) * NOTES_PER_OCT +
		NOTE_CALC_W'(idx_q);

	// Event built from the entry under evaluation.
	always_comb begin
		if (is_hold) begin
			new_ev.kind        = hold_next ? EV_HOLD_ON : EV_HOLD_OFF;
			new_ev.note        = '0;
			new_ev.key_index   = '0;
			new_ev.hold_active = hold_next;
		end else begin
			new_ev.kind        = level ? EV_NOTE_ON : EV_NOTE_OFF;
			new_ev.note        = (note_sum > NOTE_MAX) ? NOTE_MAX[NOTE_W-1:0]
				: note_sum[NOTE_W-1:0];
			new_ev.key_index   = KIDX_W'(idx_q);
			new_ev.hold_active = hold_on_q;
		end
	end

	// Sequencer: one entry per cycle unless stalled; an event stays pending
	// until the next one is found or the scan ends, which decides its last flag.
	always_comb begin
		state_d   = state_q;
		advance   = 1'b0;
		load_out  = 1'b0;
		load_ev   = pend_q;
		load_last = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ram_re  = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!(emits && pend_valid_q && !out_free)) begin
					advance  = 1'b1;
					load_out = emits && pend_valid_q;
					if (is_hold) begin
						state_d = ST_FLUSH;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + IDX_W'(1);
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Write back the accepted change.
	assign ram_we    = advance && change_ok;
	assign ram_waddr = idx_q;
	assign ram_wdata = {level, now_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			entry_valid_q <= '0;
			hold_on_q     <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= '0;
			end else if (advance && !is_hold) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (ram_we) begin
				entry_valid_q[idx_q] <= 1'b1;
			end
			if (advance && emits && is_hold) begin
				hold_on_q <= hold_next;
			end
			if (advance && emits) begin
				pend_valid_q <= 1'b1;
			end else if (load_out && load_last) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= time_ms;
			lvl_q <= lvl_next;
		end
		if (advance && emits) begin
			pend_q <= new_ev;
		end
		if (load_out) begin
			out_q      <= load_ev;
			out_last_q <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_event = out_q;
	assign out_last  = out_last_q;

endmodule

/* dv/key_debounce_note_events_test.sv */
`timescale 1ns / 100ps

module key_debounce_note_events_test;
	import kdne_pkg::*;

	localparam int KEYS        = NUM_KEYS_DEF;
	localparam int SETTLE      = 40;
	localparam int HOLD_OFF    = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 6;
	localparam int PHASE_SCANS = 32;

	// One expected event beat.
	typedef struct {
		kind_t             kind;
		logic [NOTE_W-1:0] note;
		logic [KIDX_W-1:0] key_index;
		logic              hold_active;
		logic              last;
	} note_event_t;

	// Tracks debounce state and holds the note events still owed by the block.
	class debounce_scoreboard;
		logic [DEB_W-1:0]  lockout_span;
		logic [OCT_W-1:0]  octave_base;
		logic              key_down [KEYS];
		logic [TIME_W-1:0] key_stamp [KEYS];
		logic              hold_down;
		logic [TIME_W-1:0] hold_stamp;
		logic              hold_latched;
		note_event_t       pending_events [$];
		int                errors;

		function new();
			lockout_span = DEB_RESET;
			octave_base  = OCT_RESET;
			foreach (key_down[k]) begin
				key_down[k]  = 1'b0;
				key_stamp[k] = '0;
			end
			hold_down    = 1'b0;
			hold_stamp   = '0;
			hold_latched = 1'b0;
			errors       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_DEBOUNCE: lockout_span = value[DEB_W-1:0];
				REG_OCTAVE:   octave_base  = value[OCT_W-1:0];
				default:      ;
			endcase
		endfunction

		// Note numbers saturate at the top of the MIDI range.
		function logic [NOTE_W-1:0] note_number(int k);
			int n;
			n = (int'(octave_base) + 1) * int'(NOTES_PER_OCT) + k;
			if (n > int'(NOTE_MAX))
				n = int'(NOTE_MAX);
			return n[NOTE_W-1:0];
		endfunction

		// Works out every event that one accepted scan causes.
		function void note_scan(logic [TIME_W-1:0] now, logic [KEY_W-1:0] levels,
				logic level_hold);
			note_event_t       ev;
			note_event_t       scan_events [$];
			logic [TIME_W-1:0] elapsed;

			for (int k = 0; k < KEYS; k++) begin
				elapsed = now - key_stamp[k];
				if (levels[k] != key_down[k] && elapsed > TIME_W'(lockout_span)) begin
					key_stamp[k]   = now;
					key_down[k]    = levels[k];
					ev.kind        = levels[k] ? EV_NOTE_ON : EV_NOTE_OFF;
					ev.note        = note_number(k);
					ev.key_index   = k[KIDX_W-1:0];
					ev.hold_active = hold_latched;
					ev.last        = 1'b0;
					scan_events.push_back(ev);
				end
			end

			// Only a press of the hold key toggles hold; a release just settles.
			elapsed = now - hold_stamp;
			if (level_hold != hold_down && elapsed > TIME_W'(lockout_span)) begin
				hold_stamp = now;
				hold_down  = level_hold;
				if (level_hold) begin
					hold_latched   = !hold_latched;
					ev.kind        = hold_latched ? EV_HOLD_ON : EV_HOLD_OFF;
					ev.note        = '0;
					ev.key_index   = '0;
					ev.hold_active = hold_latched;
					ev.last        = 1'b0;
					scan_events.push_back(ev);
				end
			end

			if (scan_events.size() > 0)
				scan_events[scan_events.size() - 1].last = 1'b1;
			foreach (scan_events[i])
				pending_events.push_back(scan_events[i]);
		endfunction

		function void check_event(logic [KIND_W-1:0] got_kind, logic [NOTE_W-1:0] got_note,
				logic [KIDX_W-1:0] got_key, logic got_hold, logic got_last);
			note_event_t exp;

			if (pending_events.size() == 0) begin
				$error("event beat with nothing expected: kind %0d note %0d key %0d",
					got_kind, got_note, got_key);
				errors++;
				return;
			end
			exp = pending_events.pop_front();
			if (got_kind !== exp.kind) begin
				$error("event_kind: expected %0d, actual %0d", exp.kind, got_kind);
				errors++;
			end
			if (got_note !== exp.note) begin
				$error("note: expected %0d, actual %0d", exp.note, got_note);
				errors++;
			end
			if (got_key !== exp.key_index) begin
				$error("key_index: expected %0d, actual %0d", exp.key_index, got_key);
				errors++;
			end
			if (got_hold !== exp.hold_active) begin
				$error("hold_active: expected %0d, actual %0d", exp.hold_active, got_hold);
				errors++;
			end
			if (got_last !== exp.last) begin
				$error("last: expected %0d, actual %0d", exp.last, got_last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_events.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [TIME_W-1:0]     time_ms;
	logic [KEY_W-1:0]      key_levels;
	logic                  hold_level;
	logic                  out_valid;
	logic                  out_stall;
	logic [KIND_W-1:0]     event_kind;
	logic [NOTE_W-1:0]     note;
	logic [KIDX_W-1:0]     key_index;
	logic                  hold_active;
	logic                  last;

	debounce_scoreboard sb;
	logic               calm = 1'b0;
	logic               hold_off_req = 1'b0;
	int                 cycle_count = 0;

	key_debounce_note_events u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.time_ms    (time_ms),
		.key_levels (key_levels),
		.hold_level (hold_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.note       (note),
		.key_index  (key_index),
		.hold_active(hold_active),
		.last       (last)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit, in case the block hangs or owes beats forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Every accepted event beat is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_event(event_kind, note, key_index, hold_active, last);
	end

	// Receiver stall: short random bursts, plus one long hold-off on request.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one scan beat and waits until the block takes it. Valid is left high
	// so that a back-to-back beat needs no second assignment in the same step.
	task automatic send_scan(input logic [TIME_W-1:0] t, input logic [KEY_W-1:0] lv,
			input logic hl);
		in_valid   <= 1'b1;
		time_ms    <= t;
		key_levels <= lv;
		hold_level <= hl;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_scan(t, lv, hl);
	endtask

	// Stops sending and waits until every owed event has arrived and the block
	// has had time to finish any quiet scan.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [TIME_W-1:0] now;
		logic [KEY_W-1:0]  lv;
		logic              hl;
		int                deb;
		int                r;

		sb = new();
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_idx    <= REG_DEBOUNCE;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		time_ms    <= '0;
		key_levels <= '0;
		hold_level <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings: the exact debounce boundary, every
		// key at once with the hold press, releases under hold, hold turned off.
		send_scan(32'd0, 13'h1FFF, 1'b1);
		send_scan(32'd120, 13'h1FFF, 1'b1);
		send_scan(32'd121, 13'h1FFF, 1'b1);
		send_scan(32'd200, 13'h0000, 1'b0);
		send_scan(32'd241, 13'h0000, 1'b0);
		send_scan(32'd242, 13'h0000, 1'b0);
		send_scan(32'd400, 13'h0000, 1'b1);
		// Timestamps that wrap around the 32-bit range.
		send_scan(32'hFFFF_FF00, 13'h1555, 1'b0);
		send_scan(32'h0000_0010, 13'h0AAA, 1'b1);

		// Octave past the top of the range saturates the note; zero debounce.
		set_reg(REG_OCTAVE, 16'd15);
		set_reg(REG_DEBOUNCE, 16'd0);
		send_scan(32'h0000_0010, 13'h1FFF, 1'b0);
		send_scan(32'h0000_0011, 13'h1FFF, 1'b0);

		// Lowest octave with the longest debounce time.
		set_reg(REG_OCTAVE, 16'd0);
		set_reg(REG_DEBOUNCE, 16'hFFFF);
		send_scan(32'h0001_0010, 13'h0000, 1'b1);
		send_scan(32'h0001_0011, 13'h0000, 1'b1);

		// Top legal octave, then one that saturates only the upper keys.
		set_reg(REG_OCTAVE, 16'd8);
		set_reg(REG_DEBOUNCE, 16'd1);
		send_scan(32'h0001_0012, 13'h1FFF, 1'b1);
		send_scan(32'h0001_0013, 13'h1FFF, 1'b1);
		set_reg(REG_OCTAVE, 16'd9);
		send_scan(32'h0001_0015, 13'h0F0F, 1'b0);
		send_scan(32'h0001_0017, 13'h10F0, 1'b1);

		// Random phases, each under its own settings. Most scans advance time by
		// amounts near the debounce time and flip a key or two, so changes are
		// both rejected and accepted; the rest jump in time or scramble levels.
		now = 32'h0001_0017;
		lv  = 13'h10F0;
		hl  = 1'b1;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: deb = $urandom_range(0, 300);
				1: deb = 0;
				2: deb = 65535;
				3: deb = $urandom_range(1, 40);
				4: deb = $urandom_range(0, 65535);
				default: deb = 120;
			endcase
			set_reg(REG_DEBOUNCE, deb[CFG_DATA_W-1:0]);
			case (phase)
				0: set_reg(REG_OCTAVE, 16'($urandom_range(0, 8)));
				1: set_reg(REG_OCTAVE, 16'd8);
				2: set_reg(REG_OCTAVE, 16'd0);
				3: set_reg(REG_OCTAVE, 16'($urandom_range(0, 15)));
				4: set_reg(REG_OCTAVE, 16'($urandom_range(9, 15)));
				default: set_reg(REG_OCTAVE, 16'd2);
			endcase
			calm = (phase == PHASES - 1);

			for (int i = 0; i < PHASE_SCANS; i++) begin
				// Long receiver hold-off while scans keep coming.
				if (phase == 1 && i == 4)
					hold_off_req = 1'b1;
				// Sender waits for every owed event mid-phase.
				if (phase == 2 && i == 17)
					wait_drained();

				r = $urandom_range(0, 99);
				if (r < 80)
					now = now + TIME_W'($urandom_range(0, 2 * deb + 2));
				else if (r < 90)
					now = $urandom();
				else
					now = now - TIME_W'($urandom_range(0, deb));

				if ($urandom_range(0, 3) == 0) begin
					lv = KEY_W'($urandom());
				end else begin
					lv[$urandom_range(0, KEYS - 1)] ^= 1'b1;
					if ($urandom_range(0, 1) == 0)
						lv[$urandom_range(0, KEYS - 1)] ^= 1'b1;
				end
				if ($urandom_range(0, 3) == 0)
					hl = !hl;

				send_scan(now, lv, hl);
				if (!calm && $urandom_range(0, 3) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
		end

		wait_drained();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
design/kdne_pkg.sv
design/kdne_ram.sv
design/kdne_ctrl.sv
design/key_debounce_note_events.sv
dv/key_debounce_note_events_test.sv
